@@ rtl/spadd_pkg.sv @@
// Package with the shared constants, codes and types of the sparse polynomial adder.
package spadd_pkg;

   localparam int TERM_DEPTH = 16;
   localparam int IDX_W = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
   localparam int CNT_W = $clog2(TERM_DEPTH + 1);
   localparam int COEFF_W = 32;
   localparam int SUM_W = 33;
   localparam int EXP_W = 16;

   typedef enum logic [1:0] {
      FUNC_APPEND_A = 2'd0,
      FUNC_APPEND_B = 2'd1,
      FUNC_RUN      = 2'd2
   } func_type;

   typedef struct packed {
      logic                     take_a;
      logic                     take_b;
      logic                     emit;
      logic signed [SUM_W-1:0]  coeff;
      logic [EXP_W-1:0]         exp;
   } step_type;

endpackage

@@ rtl/sparse_polynomial_add_merge.sv @@
// Top level of the sparse polynomial adder: term buffers, merge sequencer and result register.
//
// A command word is taken at a clock edge where start is high and busy is low.
// An append word (first or second list) leaves busy low, so
// appends may follow each other in every cycle. A term appended to a full list
// is dropped and raises the overflow flag, which every result of the next run
// carries. A run word raises busy and walks both buffers with one shared
// compare and add unit, one step per cycle. A step that yields a term pushes
// the term held from the previous step out on the result ports, so the final
// term can carry last_term. The last result of a run appears in the same cycle
// as busy goes low again. A run with no surviving term gives one word with
// empty_sum set and a zero coefficient and exponent.
// Each result word is valid for exactly one cycle, marked by rsp_strobe; the
// receiver cannot stall. Both lists and the overflow flag clear at the end
// of a run. Synchronous reset empties both lists and clears the flag; the
// buffer contents themselves are not cleared.
module sparse_polynomial_add_merge (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_func,
   input  logic signed [spadd_pkg::COEFF_W-1:0]   req_term_coeff,
   input  logic [spadd_pkg::EXP_W-1:0]            req_term_exp,
   output logic                                   rsp_strobe,
   output logic signed [spadd_pkg::SUM_W-1:0]     rsp_sum_coeff,
   output logic [spadd_pkg::EXP_W-1:0]            rsp_sum_exp,
   output logic                                   rsp_last_term,
   output logic                                   rsp_empty_sum,
   output logic                                   rsp_overflow
);
   import spadd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type state_ff;

   logic signed [COEFF_W-1:0] a_coeffs_ff [TERM_DEPTH];
   logic [EXP_W-1:0]          a_exps_ff   [TERM_DEPTH];
   logic signed [COEFF_W-1:0] b_coeffs_ff [TERM_DEPTH];
   logic [EXP_W-1:0]          b_exps_ff   [TERM_DEPTH];

   logic [CNT_W-1:0] a_count_ff;
   logic [CNT_W-1:0] b_count_ff;
   logic [CNT_W-1:0] a_idx_ff;
   logic [CNT_W-1:0] b_idx_ff;
   logic             dropped_ff;

   logic signed [SUM_W-1:0] pend_coeff_ff;
   logic [EXP_W-1:0]        pend_exp_ff;
   logic                    pend_valid_ff;

   logic                    rsp_strobe_ff;
   logic signed [SUM_W-1:0] rsp_coeff_ff;
   logic [EXP_W-1:0]        rsp_exp_ff;
   logic                    rsp_last_ff;
   logic                    rsp_empty_ff;
   logic                    rsp_overflow_ff;

   logic     accept;
   logic     a_valid;
   logic     b_valid;
   step_type step;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign a_valid = a_idx_ff < a_count_ff;
   assign b_valid = b_idx_ff < b_count_ff;

   spadd_merge_unit u_unit (
      .a_valid (a_valid),
      .a_coeff (a_coeffs_ff[a_idx_ff[IDX_W-1:0]]),
      .a_exp   (a_exps_ff[a_idx_ff[IDX_W-1:0]]),
      .b_valid (b_valid),
      .b_coeff (b_coeffs_ff[b_idx_ff[IDX_W-1:0]]),
      .b_exp   (b_exps_ff[b_idx_ff[IDX_W-1:0]]),
      .step    (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         a_count_ff    <= '0;
         b_count_ff    <= '0;
         a_idx_ff      <= '0;
         b_idx_ff      <= '0;
         dropped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_strobe_ff <= 1'b0;
               if (accept) begin
                  unique case (req_func)
                     FUNC_APPEND_A: begin
                        if (a_count_ff < CNT_W'(TERM_DEPTH)) begin
                           a_coeffs_ff[a_count_ff[IDX_W-1:0]] <= req_term_coeff;
                           a_exps_ff[a_count_ff[IDX_W-1:0]]   <= req_term_exp;
                           a_count_ff <= a_count_ff + CNT_W'(1);
                        end else begin
                           dropped_ff <= 1'b1;
                        end
                     end
                     FUNC_APPEND_B: begin
                        if (b_count_ff < CNT_W'(TERM_DEPTH)) begin
                           b_coeffs_ff[b_count_ff[IDX_W-1:0]] <= req_term_coeff;
                           b_exps_ff[b_count_ff[IDX_W-1:0]]   <= req_term_exp;
                           b_count_ff <= b_count_ff + CNT_W'(1);
                        end else begin
                           dropped_ff <= 1'b1;
                        end
                     end
                     FUNC_RUN: begin
                        a_idx_ff      <= '0;
                        b_idx_ff      <= '0;
                        pend_valid_ff <= 1'b0;
                        state_ff      <= ST_MERGE;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_MERGE: begin
               if (!a_valid && !b_valid) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_last_ff     <= 1'b1;
                  rsp_empty_ff    <= !pend_valid_ff;
                  rsp_coeff_ff    <= pend_valid_ff ? pend_coeff_ff : '0;
                  rsp_exp_ff      <= pend_valid_ff ? pend_exp_ff : '0;
                  rsp_overflow_ff <= dropped_ff;
                  a_count_ff      <= '0;
                  b_count_ff      <= '0;
                  dropped_ff      <= 1'b0;
                  pend_valid_ff   <= 1'b0;
                  state_ff        <= ST_IDLE;
               end else begin
                  rsp_strobe_ff <= step.emit && pend_valid_ff;
                  if (step.take_a) begin
                     a_idx_ff <= a_idx_ff + CNT_W'(1);
                  end
                  if (step.take_b) begin
                     b_idx_ff <= b_idx_ff + CNT_W'(1);
                  end
                  if (step.emit) begin
                     rsp_last_ff     <= 1'b0;
                     rsp_empty_ff    <= 1'b0;
                     rsp_coeff_ff    <= pend_coeff_ff;
                     rsp_exp_ff      <= pend_exp_ff;
                     rsp_overflow_ff <= dropped_ff;
                     pend_coeff_ff   <= step.coeff;
                     pend_exp_ff     <= step.exp;
                     pend_valid_ff   <= 1'b1;
                  end
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_sum_coeff = rsp_coeff_ff;
   assign rsp_sum_exp   = rsp_exp_ff;
   assign rsp_last_term = rsp_last_ff;
   assign rsp_empty_sum = rsp_empty_ff;
   assign rsp_overflow  = rsp_overflow_ff;

   a_strobe_from_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_MERGE))
      else $error("Result word without a preceding merge step.");

   a_empty_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_empty_sum |-> rsp_last_term && rsp_sum_coeff == '0)
      else $error("Empty sum word is not a final zero word.");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_term |-> state_ff == ST_IDLE && a_count_ff == '0
         && b_count_ff == '0)
      else $error("Run did not end with its final word.");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> a_idx_ff <= a_count_ff && b_idx_ff <= b_count_ff)
      else $error("Merge index ran past its list.");

endmodule

@@ rtl/spadd_merge_unit.sv @@
// Shared compare and add unit that decides one step of the merge walk.
module spadd_merge_unit (
   input  logic                                   a_valid,
   input  logic signed [spadd_pkg::COEFF_W-1:0]   a_coeff,
   input  logic [spadd_pkg::EXP_W-1:0]            a_exp,
   input  logic                                   b_valid,
   input  logic signed [spadd_pkg::COEFF_W-1:0]   b_coeff,
   input  logic [spadd_pkg::EXP_W-1:0]            b_exp,
   output spadd_pkg::step_type                    step
);
   import spadd_pkg::*;

   logic signed [SUM_W-1:0] a_wide;
   logic signed [SUM_W-1:0] b_wide;
   logic signed [SUM_W-1:0] sum;
   logic                    a_greater;
   logic                    b_greater;

   assign a_wide    = {a_coeff[COEFF_W-1], a_coeff};
   assign b_wide    = {b_coeff[COEFF_W-1], b_coeff};
   assign sum       = a_wide + b_wide;
   assign a_greater = a_exp > b_exp;
   assign b_greater = a_exp < b_exp;

   always_comb begin
      step = '0;
      if (a_valid && (!b_valid || a_greater)) begin
         step.take_a = 1'b1;
         step.emit   = 1'b1;
         step.coeff  = a_wide;
         step.exp    = a_exp;
      end else if (b_valid && (!a_valid || b_greater)) begin
         step.take_b = 1'b1;
         step.emit   = 1'b1;
         step.coeff  = b_wide;
         step.exp    = b_exp;
      end else if (a_valid && b_valid) begin
         step.take_a = 1'b1;
         step.take_b = 1'b1;
         step.emit   = (sum != '0);
         step.coeff  = sum;
         step.exp    = a_exp;
      end
   end

endmodule

@@ verif/tb_sparse_polynomial_add_merge.sv @@
// Self-checking testbench for the sparse polynomial adder, with directed and random term lists.
module tb_sparse_polynomial_add_merge;
   timeunit 1ns;
   timeprecision 1ps;

   import spadd_pkg::*;

   localparam logic [1:0] FUNC_IGNORED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 124;
   localparam int CALM_AFTER = 100;

   typedef struct packed {
      logic signed [SUM_W-1:0] coeff;
      logic [EXP_W-1:0]        exp;
      logic                    last;
      logic                    empty;
      logic                    ovf;
   } term_word_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         reps;
      logic [COEFF_W-1:0] coeff;
      logic [EXP_W-1:0]   exp;
      logic               fixed;
      term_word_type      expected;
   } stim_row_type;

   localparam term_word_type NO_TERM = '0;
   localparam term_word_type EMPTY_SUM = '{coeff: '0, exp: '0, last: 1'b1, empty: 1'b1,
                                           ovf: 1'b0};
   localparam term_word_type EMPTY_DROPPED = '{coeff: '0, exp: '0, last: 1'b1, empty: 1'b1,
                                               ovf: 1'b1};

   stim_row_type directed_rows [25] = '{
      '{FUNC_RUN,      8'd1,  32'd0,        16'd0,     1'b1, EMPTY_SUM},
      '{FUNC_APPEND_A, 8'd1,  32'h7FFFFFFF, 16'd65535, 1'b0, NO_TERM},
      '{FUNC_APPEND_B, 8'd1,  32'h7FFFFFFF, 16'd65535, 1'b0, NO_TERM},
      '{FUNC_APPEND_A, 8'd1,  32'h80000000, 16'd0,     1'b0, NO_TERM},
      '{FUNC_APPEND_B, 8'd1,  32'h80000000, 16'd0,     1'b0, NO_TERM},
      '{FUNC_RUN,      8'd1,  32'd0,        16'd0,     1'b0, NO_TERM},
      '{FUNC_APPEND_A, 8'd1,  32'd5,        16'd10,    1'b0, NO_TERM},
      '{FUNC_APPEND_B, 8'd1,  32'hFFFFFFFB, 16'd10,    1'b0, NO_TERM},
      '{FUNC_RUN,      8'd1,  32'd0,        16'd0,     1'b1, EMPTY_SUM},
      '{FUNC_IGNORED,  8'd1,  32'hFFFFFFFF, 16'hFFFF,  1'b0, NO_TERM},
      '{FUNC_APPEND_A, 8'd1,  32'd1,        16'd3,     1'b0, NO_TERM},
      '{FUNC_APPEND_A, 8'd1,  32'd2,        16'd7,     1'b0, NO_TERM},
      '{FUNC_APPEND_B, 8'd1,  32'd3,        16'd5,     1'b0, NO_TERM},
      '{FUNC_APPEND_B, 8'd1,  32'd4,        16'd3,     1'b0, NO_TERM},
      '{FUNC_RUN,      8'd1,  32'd0,        16'd0,     1'b0, NO_TERM},
      '{FUNC_APPEND_A, 8'd1,  32'd1,        16'd4,     1'b0, NO_TERM},
      '{FUNC_APPEND_A, 8'd1,  32'd2,        16'd4,     1'b0, NO_TERM},
      '{FUNC_APPEND_B, 8'd1,  32'hFFFFFFFF, 16'd4,     1'b0, NO_TERM},
      '{FUNC_RUN,      8'd1,  32'd0,        16'd0,     1'b0, NO_TERM},
      '{FUNC_APPEND_A, 8'd16, 32'd11,       16'd65535, 1'b0, NO_TERM},
      '{FUNC_APPEND_B, 8'd16, 32'hFFFFFFFD, 16'd40000, 1'b0, NO_TERM},
      '{FUNC_RUN,      8'd1,  32'd0,        16'd0,     1'b0, NO_TERM},
      '{FUNC_APPEND_A, 8'd17, 32'd7,        16'd200,   1'b0, NO_TERM},
      '{FUNC_APPEND_B, 8'd16, 32'hFFFFFFF9, 16'd200,   1'b0, NO_TERM},
      '{FUNC_RUN,      8'd1,  32'd0,        16'd0,     1'b1, EMPTY_DROPPED}
   };

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_func = '0;
   logic signed [COEFF_W-1:0] req_term_coeff = '0;
   logic [EXP_W-1:0] req_term_exp = '0;
   logic rsp_strobe;
   logic signed [SUM_W-1:0] rsp_sum_coeff;
   logic [EXP_W-1:0] rsp_sum_exp;
   logic rsp_last_term;
   logic rsp_empty_sum;
   logic rsp_overflow;

   logic fixed_en = 1'b0;
   term_word_type fixed_word = '0;

   logic signed [COEFF_W-1:0] term_coeffs [2][TERM_DEPTH];
   logic [EXP_W-1:0] term_exps [2][TERM_DEPTH];
   int list_len [2] = '{0, 0};
   logic terms_dropped = 1'b0;

   term_word_type expected_terms [$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int random_items = 0;
   bit idling = 1'b1;

   sparse_polynomial_add_merge DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_term_coeff(req_term_coeff),
      .req_term_exp(req_term_exp),
      .rsp_strobe(rsp_strobe),
      .rsp_sum_coeff(rsp_sum_coeff),
      .rsp_sum_exp(rsp_sum_exp),
      .rsp_last_term(rsp_last_term),
      .rsp_empty_sum(rsp_empty_sum),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      mismatches++;
   endtask

   function automatic term_word_type pass_term(input logic signed [SUM_W-1:0] c,
                                               input logic [EXP_W-1:0] e);
      return '{coeff: c, exp: e, last: 1'b0, empty: 1'b0, ovf: terms_dropped};
   endfunction

   function automatic void add_polynomial_word(input logic [1:0] f,
                                               input logic signed [COEFF_W-1:0] c,
                                               input logic [EXP_W-1:0] e,
                                               input bit keep);
      term_word_type sum_terms [$];
      logic signed [SUM_W-1:0] s;
      int i;
      int j;
      i = 0;
      j = 0;
      case (f) inside
         FUNC_APPEND_A, FUNC_APPEND_B: begin
            if (list_len[f[0]] < TERM_DEPTH) begin
               term_coeffs[f[0]][list_len[f[0]]] = c;
               term_exps[f[0]][list_len[f[0]]] = e;
               list_len[f[0]]++;
            end else begin
               terms_dropped = 1'b1;
            end
         end
         FUNC_RUN: begin
            while (i < list_len[0] && j < list_len[1]) begin
               if (term_exps[0][i] > term_exps[1][j]) begin
                  sum_terms.push_back(pass_term(term_coeffs[0][i], term_exps[0][i]));
                  i++;
               end else if (term_exps[0][i] < term_exps[1][j]) begin
                  sum_terms.push_back(pass_term(term_coeffs[1][j], term_exps[1][j]));
                  j++;
               end else begin
                  s = term_coeffs[0][i] + term_coeffs[1][j];
                  if (s != 0) sum_terms.push_back(pass_term(s, term_exps[0][i]));
                  i++;
                  j++;
               end
            end
            while (i < list_len[0]) begin
               sum_terms.push_back(pass_term(term_coeffs[0][i], term_exps[0][i]));
               i++;
            end
            while (j < list_len[1]) begin
               sum_terms.push_back(pass_term(term_coeffs[1][j], term_exps[1][j]));
               j++;
            end
            if (sum_terms.size() == 0) begin
               sum_terms.push_back(pass_term('0, '0));
               sum_terms[0].empty = 1'b1;
            end
            sum_terms[sum_terms.size()-1].last = 1'b1;
            if (keep) begin
               foreach (sum_terms[k]) expected_terms.push_back(sum_terms[k]);
            end
            list_len[0] = 0;
            list_len[1] = 0;
            terms_dropped = 1'b0;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      term_word_type got;
      term_word_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{coeff: rsp_sum_coeff, exp: rsp_sum_exp, last: rsp_last_term,
                    empty: rsp_empty_sum, ovf: rsp_overflow};
            if (expected_terms.size() == 0) begin
               report_mismatch("unexpected result word", 64'(got), '0);
            end else begin
               want = expected_terms.pop_front();
               if (got.coeff !== want.coeff)
                  report_mismatch("sum_coeff", 64'(got.coeff), 64'(want.coeff));
               if (got.exp !== want.exp) report_mismatch("sum_exp", 64'(got.exp), 64'(want.exp));
               if (got.last !== want.last)
                  report_mismatch("last_term", 64'(got.last), 64'(want.last));
               if (got.empty !== want.empty)
                  report_mismatch("empty_sum", 64'(got.empty), 64'(want.empty));
               if (got.ovf !== want.ovf) report_mismatch("overflow", 64'(got.ovf), 64'(want.ovf));
            end
         end
         if (start && !busy) begin
            add_polynomial_word(req_func, req_term_coeff, req_term_exp, !fixed_en);
            if (fixed_en) expected_terms.push_back(fixed_word);
         end
      end
      if (rsp_strobe || (start && !busy)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [1:0] f, input logic [COEFF_W-1:0] c,
                            input logic [EXP_W-1:0] e, input logic fixed,
                            input term_word_type tw);
      int gap;
      gap = 0;
      if (idling && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_term_coeff <= c;
      req_term_exp <= e;
      fixed_en <= fixed;
      fixed_word <= tw;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [COEFF_W-1:0] random_coeff();
      case ($urandom_range(0, 7))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return '0;
         3: return 32'hFFFFFFFF;
         default: return $urandom();
      endcase
   endfunction

   // Two term lists, usually sorted, with shared exponents that often cancel.
   task automatic send_random_sum();
      logic [COEFF_W-1:0] coeffs_a [$];
      logic [COEFF_W-1:0] coeffs_b [$];
      logic [EXP_W-1:0] exps_a [$];
      logic [EXP_W-1:0] exps_b [$];
      int na;
      int nb;
      int ia;
      int ib;
      bit narrow;
      na = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      narrow = ($urandom_range(0, 1) == 1);
      repeat (na)
         exps_a.push_back(EXP_W'(narrow ? $urandom_range(0, 15) : $urandom_range(0, 65535)));
      repeat (nb)
         exps_b.push_back(EXP_W'(narrow ? $urandom_range(0, 15) : $urandom_range(0, 65535)));
      if ($urandom_range(0, 7) != 0) begin
         exps_a.rsort();
         exps_b.rsort();
      end
      foreach (exps_a[k]) coeffs_a.push_back(random_coeff());
      foreach (exps_b[k]) begin
         coeffs_b.push_back(random_coeff());
         foreach (exps_a[m])
            if (exps_a[m] == exps_b[k] && $urandom_range(0, 1) == 1) coeffs_b[k] = -coeffs_a[m];
      end
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
         if ($urandom_range(0, 15) == 0)
            send_word(FUNC_IGNORED, $urandom(), EXP_W'($urandom()), 1'b0, NO_TERM);
         if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
            send_word(FUNC_APPEND_A, coeffs_a[ia], exps_a[ia], 1'b0, NO_TERM);
            ia++;
         end else begin
            send_word(FUNC_APPEND_B, coeffs_b[ib], exps_b[ib], 1'b0, NO_TERM);
            ib++;
         end
      end
      send_word(FUNC_RUN, $urandom(), EXP_W'($urandom()), 1'b0, NO_TERM);
      random_items += na + nb + 1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[r])
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_word(directed_rows[r].func, directed_rows[r].coeff,
                      directed_rows[r].exp - EXP_W'(k), directed_rows[r].fixed,
                      directed_rows[r].expected);
      while (random_items < RANDOM_ITEMS) begin
         idling = (random_items < CALM_AFTER) && ($urandom_range(0, 9) < 7);
         send_random_sum();
      end
      start <= 1'b0;
      @(posedge clock);
      while (expected_terms.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
